FILE: design/pknn_pkg.sv
// Package for the k-nearest frame selector: widths, register codes and shared types.
// It depends on nothing; every other design file uses it.

package pknn_pkg;

    localparam int INDEX_BITS     = 8;
    localparam int NCOUNT_BITS    = 5;
    localparam int COORD_BITS     = 24;
    localparam int MAG_W          = COORD_BITS + 1;
    localparam int SQ_W           = 2 * MAG_W;
    localparam int SUM_W          = SQ_W + 2;
    localparam int DIST_BITS      = 50;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int IN_DATA_BITS   = 80;
    localparam int OUT_DATA_BITS  = 64;
    localparam int MAX_K_DEFAULT  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SELF_INDEX      = 3'd0,
        CFG_NEIGHBOUR_COUNT = 3'd1,
        CFG_SELF_X          = 3'd2,
        CFG_SELF_Y          = 3'd3,
        CFG_SELF_Z          = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]  distance;
        logic [INDEX_BITS-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   skip;
        logic   last;
        entry_t entry;
    } cand_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: design/pknn_dist.sv
// Three-stage squared-distance pipeline: differences, squares, saturating sum.
// Depends on pknn_pkg.

module pknn_dist
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_skip,
    input  logic                                      in_last,
    input  logic        [pknn_pkg::INDEX_BITS-1:0]    in_frame,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    pos_x,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    pos_y,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    pos_z,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    self_x,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    self_y,
    input  logic signed [pknn_pkg::COORD_BITS-1:0]    self_z,
    output pknn_pkg::cand_t                           cand
);

    localparam int CB = pknn_pkg::COORD_BITS;
    localparam int MW = pknn_pkg::MAG_W;
    localparam int QW = pknn_pkg::SQ_W;
    localparam int SW = pknn_pkg::SUM_W;
    localparam int DB = pknn_pkg::DIST_BITS;

    typedef struct packed {
        logic                            skip;
        logic                            last;
        logic [pknn_pkg::INDEX_BITS-1:0] frame;
    } meta_t;

    logic            v1_reg, v1_next, v2_reg, v3_reg;
    meta_t           m1_reg, m1_next, m2_reg, m3_reg;
    logic [MW-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [MW-1:0]   mag_x_next, mag_y_next, mag_z_next;
    logic [QW-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;
    logic [QW-1:0]   sq_x_next, sq_y_next, sq_z_next;
    logic [DB-1:0]   dist_reg, dist_next;
    logic signed [MW-1:0] dx, dy, dz;
    logic [SW-1:0]   sum;

    always_comb
    begin
        v1_next = in_valid;
        m1_next = '{skip: in_skip, last: in_last, frame: in_frame};
        dx = {self_x[CB-1], self_x} - {pos_x[CB-1], pos_x};
        dy = {self_y[CB-1], self_y} - {pos_y[CB-1], pos_y};
        dz = {self_z[CB-1], self_z} - {pos_z[CB-1], pos_z};
        mag_x_next = dx[MW-1] ? MW'(-dx) : MW'(dx);
        mag_y_next = dy[MW-1] ? MW'(-dy) : MW'(dy);
        mag_z_next = dz[MW-1] ? MW'(-dz) : MW'(dz);
        sq_x_next = QW'(mag_x_reg) * QW'(mag_x_reg);
        sq_y_next = QW'(mag_y_reg) * QW'(mag_y_reg);
        sq_z_next = QW'(mag_z_reg) * QW'(mag_z_reg);
        sum = SW'(sq_x_reg) + SW'(sq_y_reg) + SW'(sq_z_reg);
        if (|sum[SW-1:DB])
        begin
            dist_next = '1;
        end
        else
        begin
            dist_next = sum[DB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg    <= m1_next;
        m2_reg    <= m1_reg;
        m3_reg    <= m2_reg;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        mag_z_reg <= mag_z_next;
        sq_x_reg  <= sq_x_next;
        sq_y_reg  <= sq_y_next;
        sq_z_reg  <= sq_z_next;
        dist_reg  <= dist_next;
    end

    assign cand = '{valid: v3_reg, skip: m3_reg.skip, last: m3_reg.last,
                    entry: '{distance: dist_reg, frame: m3_reg.frame}};

endmodule

FILE: design/pknn_cell.sv
// One cell of the sorted list: holds one entry, compares it with the candidate
// and takes the candidate, its upper neighbor's entry or its lower neighbor's entry.
// Depends on pknn_pkg.

module pknn_cell
(
    input  logic                 clk,
    input  pknn_pkg::cell_ctrl_t ctrl,
    input  pknn_pkg::entry_t     cand,
    input  logic                 occupied,
    input  logic                 prev_ahead,
    input  pknn_pkg::entry_t     prev_entry,
    input  pknn_pkg::entry_t     next_entry,
    output pknn_pkg::entry_t     entry,
    output logic                 ahead
);

    pknn_pkg::entry_t entry_reg, entry_next;

    always_comb
    begin
        ahead = !occupied ||
                ({cand.distance, cand.frame} < {entry_reg.distance, entry_reg.frame});
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert)
        begin
            if (prev_ahead)
            begin
                entry_next = prev_entry;
            end
            else if (ahead)
            begin
                entry_next = cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: design/pose_knn_neighbour_select.sv
// Top level of the k-nearest frame selector: configuration registers, distance
// pipeline, chain of sorted-list cells and the output sequencer.
// Depends on pknn_pkg, pknn_dist and pknn_cell.
//
//  Channel   Direction  Signals                          Content
//  s_axis    in         tvalid tready tdata[79:0] tlast  frame_index, pos_x/y/z; last_frame
//  m_axis    out        tvalid tready tdata[63:0] tlast  neighbour_index, squared_distance
//  cfg       in         cfg_we cfg_index cfg_data        register writes, no read-back
//
// One candidate is accepted per cycle until a tlast transfer; s_axis_tready then
// stays low until that candidate has passed the distance pipeline and the query's
// neighbours are sent. In the cell chain all cells update in the same cycle. Results
// leave one per cycle from the head cell; a stall on m_axis holds the chain.
// Reset presets the list count, the sequencer and the registers; no clearing pass.

module pose_knn_neighbour_select
#(
    parameter int MAX_K = pknn_pkg::MAX_K_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // frame_index[7:0], pos_x[31:8], pos_y[55:32], pos_z[79:56]
    input  logic [pknn_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // neighbour_index[7:0], squared_distance[57:8], zeros[63:58]
    output logic [pknn_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_we,
    input  logic [pknn_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pknn_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int IB    = pknn_pkg::INDEX_BITS;
    localparam int CB    = pknn_pkg::COORD_BITS;
    localparam int PAD_W = pknn_pkg::OUT_DATA_BITS - pknn_pkg::DIST_BITS - IB;

    logic [IB-1:0]                      self_index_reg;
    logic [pknn_pkg::NCOUNT_BITS-1:0]   ncount_reg;
    logic signed [CB-1:0]               self_x_reg, self_y_reg, self_z_reg;

    pknn_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next, remain_reg, remain_next;
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   fill_after, k_eff, n_out;
    logic [7:0]         ncount_wide;
    logic               in_xfer, out_xfer;

    pknn_pkg::cand_t      cand;
    pknn_pkg::cell_ctrl_t ctrl;
    pknn_pkg::entry_t     cell_entry [MAX_K];
    logic                 cell_ahead [MAX_K];

    assign s_axis_tready = !busy_reg;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_index_reg <= '0;
            ncount_reg     <= pknn_pkg::NCOUNT_BITS'(1);
            self_x_reg     <= '0;
            self_y_reg     <= '0;
            self_z_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pknn_pkg::CFG_SELF_INDEX:      self_index_reg <= cfg_data[IB-1:0];
                pknn_pkg::CFG_NEIGHBOUR_COUNT: ncount_reg <= cfg_data[pknn_pkg::NCOUNT_BITS-1:0];
                pknn_pkg::CFG_SELF_X:          self_x_reg <= cfg_data[CB-1:0];
                pknn_pkg::CFG_SELF_Y:          self_y_reg <= cfg_data[CB-1:0];
                pknn_pkg::CFG_SELF_Z:          self_z_reg <= cfg_data[CB-1:0];
                default:                       ;
            endcase
        end
    end

    pknn_dist u_dist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_xfer),
        .in_skip  (s_axis_tdata[IB-1:0] == self_index_reg),
        .in_last  (s_axis_tlast),
        .in_frame (s_axis_tdata[IB-1:0]),
        .pos_x    (s_axis_tdata[IB+CB-1:IB]),
        .pos_y    (s_axis_tdata[IB+2*CB-1:IB+CB]),
        .pos_z    (s_axis_tdata[IB+3*CB-1:IB+2*CB]),
        .self_x   (self_x_reg),
        .self_y   (self_y_reg),
        .self_z   (self_z_reg),
        .cand     (cand)
    );

    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        logic             prev_ahead;
        pknn_pkg::entry_t prev_entry, next_entry;

        if (i == 0)
        begin : g_head
            assign prev_ahead = 1'b0;
            assign prev_entry = cand.entry;
        end
        else
        begin : g_body
            assign prev_ahead = cell_ahead[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == MAX_K - 1)
        begin : g_tail
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        pknn_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .cand       (cand.entry),
            .occupied   (CNT_W'(i) < fill_reg),
            .prev_ahead (prev_ahead),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .ahead      (cell_ahead[i])
        );
    end

    always_comb
    begin
        ncount_wide = {{(8 - pknn_pkg::NCOUNT_BITS){1'b0}}, ncount_reg};
        if (ncount_wide == 8'd0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (ncount_wide > 8'(MAX_K))
        begin
            k_eff = CNT_W'(MAX_K);
        end
        else
        begin
            k_eff = CNT_W'(ncount_wide);
        end
        if (!cand.skip && (fill_reg < CNT_W'(MAX_K)))
        begin
            fill_after = fill_reg + CNT_W'(1);
        end
        else
        begin
            fill_after = fill_reg;
        end
        n_out = (fill_after < k_eff) ? fill_after : k_eff;
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        busy_next   = busy_reg;
        if (in_xfer && s_axis_tlast)
        begin
            busy_next = 1'b1;
        end
        unique case (state_reg)
            pknn_pkg::ST_COLLECT:
            begin
                if (cand.valid)
                begin
                    fill_next = fill_after;
                    if (cand.last)
                    begin
                        fill_next   = '0;
                        remain_next = n_out;
                        if (n_out == '0)
                        begin
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            state_next = pknn_pkg::ST_DRAIN;
                        end
                    end
                end
            end
            pknn_pkg::ST_DRAIN:
            begin
                if (out_xfer)
                begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = pknn_pkg::ST_COLLECT;
                        busy_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = pknn_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        m_axis_tvalid = (state_reg == pknn_pkg::ST_DRAIN);
        m_axis_tlast  = (remain_reg == CNT_W'(1));
        m_axis_tdata  = {{PAD_W{1'b0}}, cell_entry[0].distance, cell_entry[0].frame};
        ctrl.shift    = (state_reg == pknn_pkg::ST_DRAIN) && m_axis_tready;
        ctrl.insert   = (state_reg == pknn_pkg::ST_COLLECT) && cand.valid && !cand.skip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pknn_pkg::ST_COLLECT;
            fill_reg   <= '0;
            remain_reg <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

FILE: design/pknn_checker.sv
// Port-level checks for the k-nearest frame selector, bound to its top level.
// Depends on pknn_pkg and pose_knn_neighbour_select.

module pknn_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pknn_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                               m_axis_tlast
);

    localparam int USED_W = pknn_pkg::DIST_BITS + pknn_pkg::INDEX_BITS;

    // Results are only offered while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("result offered while input open");

    // The input closes right after the final candidate of a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input open after final candidate");

    // Nothing more is offered after the final result of a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after final neighbour");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // The padding above the distance is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[pknn_pkg::OUT_DATA_BITS-1:USED_W] == '0))
        else $error("nonzero padding in result");

endmodule

bind pose_knn_neighbour_select pknn_checker u_pknn_checker (.*);

FILE: test/tb_pose_knn_neighbour_select.sv
`timescale 1ns / 1ps
// Self-checking testbench for pose_knn_neighbour_select: queries of candidate frames are
// streamed in, and every reported neighbour is checked against a sorted nearest-frame list
// kept here. It depends on pknn_pkg and the design files only.

module tb_pose_knn_neighbour_select;

    import pknn_pkg::*;

    localparam int MAX_K          = MAX_K_DEFAULT;
    localparam int IDLE_PERCENT   = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int HOLD_PHASE     = 6;
    localparam int STEADY_PHASE   = 3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam longint DIST_LIMIT = (longint'(1) <<< DIST_BITS) - 1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  last;
    } candidate_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  distance;
        logic                  last;
    } neighbour_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic steady = 1'b0;
    logic hold_request = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;

    candidate_t pending_frames[$];
    neighbour_t expected_neighbours[$];
    candidate_t offered;
    candidate_t next_frame;

    logic [INDEX_BITS-1:0]  near_index [MAX_K];
    logic [DIST_BITS-1:0]   near_dist [MAX_K];
    int                     near_fill = 0;
    logic [INDEX_BITS-1:0]  own_index = '0;
    logic [NCOUNT_BITS-1:0] own_count = 5'd1;
    logic [COORD_BITS-1:0]  own_x = '0;
    logic [COORD_BITS-1:0]  own_y = '0;
    logic [COORD_BITS-1:0]  own_z = '0;

    int error_count = 0;
    int frames_taken = 0;
    int queries_closed = 0;
    int neighbours_checked = 0;
    int register_writes = 0;

    pose_knn_neighbour_select u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DIST_BITS-1:0] squared_gap(input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay, input logic [COORD_BITS-1:0] az,
        input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
        input logic [COORD_BITS-1:0] bz);
        longint dx;
        longint dy;
        longint dz;
        longint sum;
        dx = longint'($signed(ax)) - longint'($signed(bx));
        dy = longint'($signed(ay)) - longint'($signed(by));
        dz = longint'($signed(az)) - longint'($signed(bz));
        sum = dx * dx + dy * dy + dz * dz;
        if (sum > DIST_LIMIT)
            sum = DIST_LIMIT;
        return sum[DIST_BITS-1:0];
    endfunction

    task automatic insert_nearest(input logic [INDEX_BITS-1:0] idx,
        input logic [DIST_BITS-1:0] sq_dist);
        int pos;
        int j;
        pos = near_fill;
        while (pos > 0 && (sq_dist < near_dist[pos-1] ||
               (sq_dist == near_dist[pos-1] && idx < near_index[pos-1])))
            pos--;
        if (pos < MAX_K)
        begin
            j = (near_fill < MAX_K) ? near_fill : MAX_K - 1;
            while (j > pos)
            begin
                near_dist[j]  = near_dist[j-1];
                near_index[j] = near_index[j-1];
                j--;
            end
            near_dist[pos]  = sq_dist;
            near_index[pos] = idx;
            if (near_fill < MAX_K)
                near_fill++;
        end
    endtask

    // Applies one accepted candidate; a closing frame publishes up to k nearest entries.
    task automatic update_nearest_list(input candidate_t f);
        int k;
        int n;
        neighbour_t nb;
        frames_taken++;
        if (f.index != own_index)
            insert_nearest(f.index, squared_gap(own_x, own_y, own_z, f.x, f.y, f.z));
        if (f.last)
        begin
            queries_closed++;
            k = (own_count == 0) ? 1 : ((own_count > MAX_K) ? MAX_K : int'(own_count));
            n = (near_fill < k) ? near_fill : k;
            for (int r = 0; r < n; r++)
            begin
                nb.index    = near_index[r];
                nb.distance = near_dist[r];
                nb.last     = (r == n - 1);
                expected_neighbours = {expected_neighbours, nb};
            end
            near_fill = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
        input longint unsigned want);
        $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got,
            want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                update_nearest_list(offered);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_frames.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    next_frame = pending_frames.pop_front();
                    offered = next_frame;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_frame.z, next_frame.y, next_frame.x,
                                      next_frame.index};
                    s_axis_tlast  <= next_frame.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left     <= 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (hold_request)
                hold_left <= HOLD_CYCLES;
            m_axis_tready <= hold_left == 0 && !hold_request &&
                             (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_neighbours.size() == 0)
            begin
                report_mismatch("unexpected neighbour", m_axis_tdata, 0);
            end
            else
            begin
                neighbours_checked++;
                if (m_axis_tdata[INDEX_BITS-1:0] != expected_neighbours[0].index)
                    report_mismatch("neighbour_index", m_axis_tdata[INDEX_BITS-1:0],
                        expected_neighbours[0].index);
                if (m_axis_tdata[INDEX_BITS +: DIST_BITS] != expected_neighbours[0].distance)
                    report_mismatch("squared_distance", m_axis_tdata[INDEX_BITS +: DIST_BITS],
                        expected_neighbours[0].distance);
                if (m_axis_tlast != expected_neighbours[0].last)
                    report_mismatch("last_neighbour", m_axis_tlast,
                        expected_neighbours[0].last);
                void'(expected_neighbours.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d frames queued and %0d neighbours due",
                    pending_frames.size(), expected_neighbours.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_register(input cfg_reg_t code, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= code;
        cfg_data  <= value;
        case (code)
            CFG_SELF_INDEX:      own_index = value[INDEX_BITS-1:0];
            CFG_NEIGHBOUR_COUNT: own_count = value[NCOUNT_BITS-1:0];
            CFG_SELF_X:          own_x = value[COORD_BITS-1:0];
            CFG_SELF_Y:          own_y = value[COORD_BITS-1:0];
            CFG_SELF_Z:          own_z = value[COORD_BITS-1:0];
            default:             ;
        endcase
        register_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_neighbours.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [INDEX_BITS-1:0] idx,
        input logic [NCOUNT_BITS-1:0] k, input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z);
        wait_drained();
        write_register(CFG_SELF_INDEX, CFG_DATA_BITS'(idx));
        write_register(CFG_NEIGHBOUR_COUNT, CFG_DATA_BITS'(k));
        write_register(CFG_SELF_X, x);
        write_register(CFG_SELF_Y, y);
        write_register(CFG_SELF_Z, z);
    endtask

    task automatic push_frame(input logic [INDEX_BITS-1:0] idx,
        input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] z, input logic last);
        candidate_t f;
        f.index = idx;
        f.x     = x;
        f.y     = y;
        f.z     = z;
        f.last  = last;
        pending_frames = {pending_frames, f};
    endtask

    // Mixes full-range values with points close to the own position so that ties occur.
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] centre);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return COORD_BITS'($urandom);
            4, 5, 6, 7: return centre + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
            8:          return COORD_MAX;
            default:    return COORD_MIN;
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index();
        case ($urandom_range(0, 15))
            0:       return own_index;
            1, 2, 3: return INDEX_BITS'($urandom_range(0, 3));
            default: return INDEX_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_queries(input int queries);
        int len;
        for (int q = 0; q < queries; q++)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_frame(pick_index(), pick_coord(own_x), pick_coord(own_y),
                    pick_coord(own_z), i == len - 1);
        end
    endtask

    initial
    begin
        logic [NCOUNT_BITS-1:0] k;
        logic [COORD_BITS-1:0]  sx;
        logic [COORD_BITS-1:0]  sy;
        logic [COORD_BITS-1:0]  sz;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // A lone own frame gives nothing; then ties on distance and on index, skipping
        // of the own frame mid-query, and a query shorter than k.
        configure(8'd5, 5'd4, '0, '0, '0);
        push_frame(8'd5, 24'd100, 24'd100, 24'd100, 1'b1);
        push_frame(8'd0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        push_frame(8'd255, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        push_frame(8'd9, 24'd1, 24'd0, 24'd0, 1'b0);
        push_frame(8'd3, 24'd0, 24'd1, 24'd0, 1'b0);
        push_frame(8'd3, 24'd0, 24'd0, 24'd1, 1'b0);
        push_frame(8'd5, 24'd0, 24'd0, 24'd0, 1'b0);
        push_frame(8'd1, 24'd0, 24'd0, 24'd0, 1'b0);
        push_frame(8'd7, COORD_MAX + 24'd1 - 24'd1 - 24'd1 + 24'd1 - 24'd1 + 24'd1 - 24'h7FFFFF
            - 24'd1, 24'd0, 24'd0, 1'b1);
        push_frame(8'd20, 24'd4096, 24'd0, 24'd0, 1'b0);
        push_frame(8'd21, 24'd0, -24'sd4096, 24'd0, 1'b1);

        // Largest distance, k of zero acting as one, and the highest own index.
        configure(8'd255, 5'd0, COORD_MIN, COORD_MIN, COORD_MIN);
        push_frame(8'd0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        push_frame(8'd255, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        push_frame(8'd128, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

        // k above the list depth with only a few candidates.
        configure(8'd0, 5'd31, COORD_MAX, COORD_MIN, '0);
        push_frame(8'd0, COORD_MAX, COORD_MIN, 24'd0, 1'b0);
        push_frame(8'd17, COORD_MIN, COORD_MAX, 24'd0, 1'b0);
        push_frame(8'd255, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0:       k = 5'd0;
                1:       k = 5'd1;
                2:       k = 5'd16;
                3:       k = NCOUNT_BITS'($urandom_range(17, 31));
                default: k = NCOUNT_BITS'($urandom_range(1, 16));
            endcase
            sx = ($urandom_range(0, 3) == 0) ? COORD_MAX : COORD_BITS'($urandom);
            sy = ($urandom_range(0, 3) == 0) ? COORD_MIN : COORD_BITS'($urandom);
            sz = ($urandom_range(0, 3) == 0) ? '0 : COORD_BITS'($urandom);
            configure(INDEX_BITS'($urandom_range(0, 255)), k, sx, sy, sz);
            if (p == STEADY_PHASE)
                steady <= 1'b1;
            if (p == HOLD_PHASE)
            begin
                hold_request <= 1'b1;
                queue_queries(6);
                while (hold_left == 0)
                    @(posedge clk);
                hold_request <= 1'b0;
            end
            else
            begin
                queue_queries(6);
            end
            wait_drained();
            steady <= 1'b0;
        end

        wait_drained();
        $display("Checked %0d neighbours from %0d queries over %0d candidate frames,",
            neighbours_checked, queries_closed, frames_taken);
        $display("with %0d register writes, random stalls and one long output hold.",
            register_writes);
        if (error_count == 0 && expected_neighbours.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
